/* hdl/wildcard_name_matcher_macros.svh */
// Assertion macros shared by the matcher RTL.
// Synthesis builds see empty bodies.
`ifndef WILDCARD_NAME_MATCHER_MACROS_SVH
`define WILDCARD_NAME_MATCHER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define WNM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wildcard_name_matcher: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WNM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wildcard_name_matcher: assertion failed");

`else

`define WNM_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define WNM_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hdl/wnm_pkg.sv */
package wnm_pkg;

   // Default number of mask bytes the store holds.
   localparam int MASK_DEPTH_DEFAULT = 256;

   // Characters with a special meaning.
   localparam logic [7:0] CH_STAR    = 8'h2a;
   localparam logic [7:0] CH_QMARK   = 8'h3f;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   // Length of the "*.*" mask, and the saturation point of the dot counter.
   localparam int         SDS_LEN    = 3;
   localparam logic [1:0] DOTS_MAX   = 2'd3;

   // Item kinds on the request channel.
   typedef enum logic [1:0] {
      KIND_MASK  = 2'd0,
      KIND_NAME  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_RSVD  = 2'd3
   } kind_type;

   // One item presented to the processing logic, with its step enable.
   typedef struct packed {
      logic       fire;
      kind_type   kind;
      logic [7:0] char_value;
      logic       last;
   } step_type;

   // Fold lower-case ASCII letters onto upper case; other bytes pass as they are.
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         r = c - CASE_DELTA;
      end
      return r;
   endfunction

endpackage

/* hdl/wnm_ram.sv */
module wnm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // One write port, two read ports with registered data (old data on a collision).
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* hdl/wnm_mask_store.sv */
module wnm_mask_store #(
   parameter int MASK_DEPTH = wnm_pkg::MASK_DEPTH_DEFAULT,
   localparam int LEN_W = $clog2(MASK_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  wnm_pkg::step_type step,
   input  logic [LEN_W-1:0]  rd_pos,
   output logic [LEN_W-1:0]  mask_len,
   output logic              star_dot_star,
   output logic [7:0]        mask_a,
   output logic [7:0]        mask_b
);

   import wnm_pkg::*;

   localparam int AW = $clog2(MASK_DEPTH);

   logic [LEN_W-1:0] load_ptr_ff;
   logic [LEN_W-1:0] load_ptr_in;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic             pat_ff;
   logic             pat_in;
   logic             sds_ff;
   logic             sds_in;
   logic             hit_a_ff;
   logic             hit_a_in;
   logic             hit_b_ff;
   logic             hit_b_in;
   logic [7:0]       wr_data_ff;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    rd_addr_a;
   logic [AW-1:0]    rd_addr_b;
   logic [LEN_W-1:0] rd_pos_next;
   logic [7:0]       ram_a;
   logic [7:0]       ram_b;
   logic [7:0]       expect_char;
   logic             pat_hit;

   wnm_ram #(
      .WIDTH (8),
      .DEPTH (MASK_DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (step.char_value),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (ram_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (ram_b)
   );

   // Store write and the two reads at the position the name reaches next.
   always_comb begin
      wr_en       = step.fire && step.kind == KIND_MASK && load_ptr_ff < LEN_W'(MASK_DEPTH);
      wr_addr     = load_ptr_ff[AW-1:0];
      rd_pos_next = rd_pos + LEN_W'(1);
      rd_addr_a   = rd_pos[AW-1:0];
      rd_addr_b   = rd_pos_next[AW-1:0];
      hit_a_in    = wr_en && wr_addr == rd_addr_a;
      hit_b_in    = wr_en && wr_addr == rd_addr_b;
   end

   // Track whether the mask being loaded so far spells "*.*".
   always_comb begin
      if (load_ptr_ff == LEN_W'(0)) begin
         expect_char = CH_STAR;
      end else if (load_ptr_ff == LEN_W'(1)) begin
         expect_char = CH_DOT;
      end else begin
         expect_char = CH_STAR;
      end
      pat_hit = load_ptr_ff < LEN_W'(SDS_LEN) && step.char_value == expect_char &&
                (load_ptr_ff == LEN_W'(0) || pat_ff);
   end

   // Load pointer, mask length and the "*.*" flag.
   always_comb begin
      load_ptr_in = load_ptr_ff;
      len_in      = len_ff;
      pat_in      = pat_ff;
      sds_in      = sds_ff;
      if (step.fire && step.kind == KIND_MASK) begin
         if (wr_en) begin
            load_ptr_in = load_ptr_ff + LEN_W'(1);
            pat_in      = pat_hit;
         end
         if (step.last) begin
            len_in      = load_ptr_in;
            sds_in      = load_ptr_in == LEN_W'(SDS_LEN) && pat_in;
            load_ptr_in = '0;
         end
      end else if (step.fire && step.kind == KIND_CLEAR) begin
         load_ptr_in = '0;
         len_in      = '0;
         sds_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff <= '0;
         len_ff      <= '0;
         pat_ff      <= 1'b0;
         sds_ff      <= 1'b0;
         hit_a_ff    <= 1'b0;
         hit_b_ff    <= 1'b0;
      end else begin
         load_ptr_ff <= load_ptr_in;
         len_ff      <= len_in;
         pat_ff      <= pat_in;
         sds_ff      <= sds_in;
         hit_a_ff    <= hit_a_in;
         hit_b_ff    <= hit_b_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_data_ff <= step.char_value;
   end

   // A byte written in the same cycle as its read is forwarded.
   assign mask_a        = hit_a_ff ? wr_data_ff : ram_a;
   assign mask_b        = hit_b_ff ? wr_data_ff : ram_b;
   assign mask_len      = len_ff;
   assign star_dot_star = sds_ff;

endmodule

/* hdl/wnm_name_track.sv */
module wnm_name_track #(
   parameter int MASK_DEPTH = wnm_pkg::MASK_DEPTH_DEFAULT,
   localparam int LEN_W = $clog2(MASK_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  wnm_pkg::step_type step,
   input  logic [LEN_W-1:0]  mask_len,
   input  logic              star_dot_star,
   input  logic [7:0]        mask_a,
   input  logic [7:0]        mask_b,
   output logic [LEN_W-1:0]  rd_pos,
   output logic              step_done,
   output logic              name_match
);

   import wnm_pkg::*;

   logic [LEN_W-1:0] pos_ff;
   logic [LEN_W-1:0] pos_in;
   logic             skip_ff;
   logic             skip_in;
   logic             fix_ff;
   logic             fix_in;
   logic             val_ff;
   logic             val_in;
   logic [1:0]       dots_ff;
   logic [1:0]       dots_in;
   logic             all_dots_ff;
   logic             all_dots_in;

   logic [7:0]       fc;
   logic [7:0]       f0;
   logic [7:0]       f1;
   logic [LEN_W-1:0] pos_p1;
   logic [LEN_W-1:0] pos_p2;
   logic [LEN_W-1:0] adv_pos;
   logic             adv_skip;
   logic             adv_fix;
   logic             adv_val;
   logic             adv_done;
   logic [1:0]       dots_next;
   logic             all_dots_next;
   logic             is_name;
   logic             restart;

   // One name byte against mask[pos] and mask[pos+1]. A '*' name byte facing
   // a run of '*' in the mask may need further passes over the same byte.
   always_comb begin
      fc       = fold_case(step.char_value);
      f0       = fold_case(mask_a);
      f1       = fold_case(mask_b);
      pos_p1   = pos_ff + LEN_W'(1);
      pos_p2   = pos_ff + LEN_W'(2);
      adv_pos  = pos_ff;
      adv_skip = skip_ff;
      adv_fix  = fix_ff;
      adv_val  = val_ff;
      adv_done = 1'b1;
      if (!fix_ff) begin
         if (skip_ff) begin
            if (pos_ff >= mask_len) begin
               adv_skip = 1'b0;
               adv_fix  = 1'b1;
               adv_val  = 1'b0;
            end else if (f0 == fc) begin
               adv_skip = 1'b0;
               adv_pos  = pos_p1;
               if (mask_a == CH_STAR) begin
                  if (pos_p1 >= mask_len) begin
                     adv_fix = 1'b1;
                     adv_val = 1'b1;
                  end else begin
                     adv_skip = 1'b1;
                     adv_done = mask_b != CH_STAR;
                  end
               end
            end
         end else begin
            if (pos_ff >= mask_len) begin
               adv_fix = 1'b1;
               adv_val = 1'b0;
            end else if (mask_a == CH_STAR) begin
               adv_pos = pos_p1;
               if (pos_p1 >= mask_len) begin
                  adv_fix = 1'b1;
                  adv_val = 1'b1;
               end else if (f1 != fc) begin
                  adv_skip = 1'b1;
               end else begin
                  adv_pos = pos_p2;
                  if (mask_b == CH_STAR) begin
                     if (pos_p2 >= mask_len) begin
                        adv_fix = 1'b1;
                        adv_val = 1'b1;
                     end else begin
                        adv_skip = 1'b1;
                        adv_done = 1'b0;
                     end
                  end
               end
            end else if (mask_a != CH_QMARK && f0 != fc) begin
               adv_fix = 1'b1;
               adv_val = 1'b0;
            end else begin
               adv_pos = pos_p1;
            end
         end
      end
   end

   // Dot bookkeeping for the special names "." and "..".
   always_comb begin
      dots_next     = dots_ff;
      all_dots_next = all_dots_ff;
      if (step.char_value == CH_DOT) begin
         if (dots_ff != DOTS_MAX) begin
            dots_next = dots_ff + 2'd1;
         end
      end else begin
         all_dots_next = 1'b0;
      end
   end

   // Verdict for a name that ends with this byte.
   always_comb begin
      if (all_dots_next && (dots_next == 2'd1 || dots_next == 2'd2)) begin
         name_match = 1'b0;
      end else if (star_dot_star) begin
         name_match = 1'b1;
      end else if (adv_fix) begin
         name_match = adv_val;
      end else begin
         name_match = !adv_skip && adv_pos == mask_len;
      end
   end

   // State update: restart on a new mask, a cleared mask or a finished name.
   always_comb begin
      is_name   = step.kind == KIND_NAME;
      step_done = !is_name || adv_done;
      restart   = step.fire && ((step.kind == KIND_MASK && step.last) ||
                                step.kind == KIND_CLEAR ||
                                (is_name && adv_done && step.last));
      pos_in      = pos_ff;
      skip_in     = skip_ff;
      fix_in      = fix_ff;
      val_in      = val_ff;
      dots_in     = dots_ff;
      all_dots_in = all_dots_ff;
      if (restart) begin
         pos_in      = '0;
         skip_in     = 1'b0;
         fix_in      = 1'b0;
         val_in      = 1'b0;
         dots_in     = '0;
         all_dots_in = 1'b1;
      end else if (step.fire && is_name) begin
         pos_in  = adv_pos;
         skip_in = adv_skip;
         fix_in  = adv_fix;
         val_in  = adv_val;
         if (adv_done) begin
            dots_in     = dots_next;
            all_dots_in = all_dots_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         skip_ff     <= 1'b0;
         fix_ff      <= 1'b0;
         val_ff      <= 1'b0;
         dots_ff     <= '0;
         all_dots_ff <= 1'b1;
      end else begin
         pos_ff      <= pos_in;
         skip_ff     <= skip_in;
         fix_ff      <= fix_in;
         val_ff      <= val_in;
         dots_ff     <= dots_in;
         all_dots_ff <= all_dots_in;
      end
   end

   // The store reads at the next position so its data lines up with pos_ff.
   assign rd_pos = pos_in;

endmodule

/* hdl/wildcard_name_matcher.sv */
// Channel  Direction  Handshake            Beat contents
// req      in         req_valid/req_ready  req_kind, req_byte_value, req_last
// rsp      out        rsp_valid/rsp_ready  rsp_match
//
// Each request beat is held in an input register and handled there, against mask
// bytes read ahead from a two-read-port RAM with registered read data.
// A new beat is taken every cycle while the held beat moves on; a name byte '*' that meets
// a run of '*' in the mask may need further passes, and stays held for them.
// A result beat waits in an output register; a name's last byte stalls only while
// that register is full and not being taken. Reset is synchronous, active high;
// the mask store itself is not cleared.
module wildcard_name_matcher #(
   parameter int MASK_DEPTH = wnm_pkg::MASK_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_byte_value,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_match
);

   import wnm_pkg::*;

   `include "wildcard_name_matcher_macros.svh"

   localparam int LEN_W = $clog2(MASK_DEPTH + 1);

   logic             s1_valid_ff;
   logic             s1_valid_in;
   kind_type         s1_kind_ff;
   logic [7:0]       s1_char_ff;
   logic             s1_last_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_match_ff;

   step_type         step;
   logic             out_ok;
   logic             step_done;
   logic             consume;
   logic             result_event;
   logic             name_match;
   logic             take;
   logic [LEN_W-1:0] rd_pos;
   logic [LEN_W-1:0] mask_len;
   logic             star_dot_star;
   logic [7:0]       mask_a;
   logic [7:0]       mask_b;

   // A name's last byte may go only when the output register can take the result.
   always_comb begin
      out_ok = !(s1_kind_ff == KIND_NAME && s1_last_ff) || !rsp_valid_ff || rsp_ready;
      step.fire       = s1_valid_ff && out_ok;
      step.kind       = s1_kind_ff;
      step.char_value = s1_char_ff;
      step.last       = s1_last_ff;
      consume         = step.fire && step_done;
      result_event    = consume && s1_kind_ff == KIND_NAME && s1_last_ff;
      req_ready       = !s1_valid_ff || consume;
      take            = req_valid && req_ready;
      s1_valid_in     = take || (s1_valid_ff && !consume);
      rsp_valid_in    = result_event || (rsp_valid_ff && !rsp_ready);
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_kind_ff <= kind_type'(req_kind);
         s1_char_ff <= req_byte_value;
         s1_last_ff <= req_last;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_event) begin
         rsp_match_ff <= name_match;
      end
   end

   wnm_mask_store #(
      .MASK_DEPTH (MASK_DEPTH)
   ) u_mask_store (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .rd_pos        (rd_pos),
      .mask_len      (mask_len),
      .star_dot_star (star_dot_star),
      .mask_a        (mask_a),
      .mask_b        (mask_b)
   );

   wnm_name_track #(
      .MASK_DEPTH (MASK_DEPTH)
   ) u_name_track (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .mask_len      (mask_len),
      .star_dot_star (star_dot_star),
      .mask_a        (mask_a),
      .mask_b        (mask_b),
      .rd_pos        (rd_pos),
      .step_done     (step_done),
      .name_match    (name_match)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match = rsp_match_ff;

   // A finished name shows up in the output register with its verdict.
   `WNM_ASSERT_NEXT(a_result_loaded, clock, reset, result_event,
                    rsp_valid_ff && rsp_match_ff == $past(name_match))
   // Only a name byte '*' ever needs another pass.
   `WNM_ASSERT_SAME(a_extra_pass_star, clock, reset, s1_valid_ff && !step_done,
                    s1_kind_ff == KIND_NAME && s1_char_ff == CH_STAR)
   // A byte that needs another pass stays in the input register.
   `WNM_ASSERT_NEXT(a_extra_pass_held, clock, reset, step.fire && !step_done,
                    s1_valid_ff && $stable(s1_char_ff) && $stable(s1_last_ff))
   // Clearing the mask leaves it empty.
   `WNM_ASSERT_NEXT(a_clear_empty, clock, reset, step.fire && s1_kind_ff == KIND_CLEAR,
                    mask_len == LEN_W'(0) && !star_dot_star)

endmodule

/* bench/tb_wildcard_name_matcher.sv */
module tb_wildcard_name_matcher;
   timeunit 1ns;
   timeprecision 1ps;

   import wnm_pkg::*;

   localparam int         CYCLE_LIMIT = 400_000;
   localparam int         DRAIN_TAIL  = 20;
   localparam bit [7:0]   CH_UPPER_A  = 8'h41;

   // Expected match bits, predicted from every accepted request beat.
   class name_match_scoreboard;
      bit [7:0] mask_store [MASK_DEPTH_DEFAULT];
      bit [8:0] mask_length;
      bit [8:0] load_pointer;
      bit [8:0] mask_position;
      bit       star_skipping;
      bit       verdict_fixed;
      bit       verdict_value;
      bit [1:0] dot_count;
      bit       all_dots;
      bit       star_dot_star;
      bit       pending_matches [$];
      int       failures;

      function new();
         all_dots = 1'b1;
      endfunction

      function bit [7:0] upcase(bit [7:0] c);
         if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            return c - CASE_DELTA;
         end
         return c;
      endfunction

      function void restart_name();
         mask_position = '0;
         star_skipping = 1'b0;
         verdict_fixed = 1'b0;
         verdict_value = 1'b0;
         dot_count     = '0;
         all_dots      = 1'b1;
      endfunction

      function void settle_verdict(bit v);
         verdict_fixed = 1'b1;
         verdict_value = v;
      endfunction

      // Walk the mask for one name byte; a star never backtracks.
      function void step_name(bit [7:0] c);
         bit [7:0] m;
         if (verdict_fixed) begin
            return;
         end
         for (int guard = 0; guard <= MASK_DEPTH_DEFAULT + 2; guard++) begin
            if (star_skipping) begin
               if (mask_position >= mask_length) begin
                  star_skipping = 1'b0;
                  settle_verdict(1'b0);
                  return;
               end
               if (upcase(mask_store[mask_position]) != upcase(c)) begin
                  return;
               end
               star_skipping = 1'b0;
            end
            if (mask_position >= mask_length) begin
               settle_verdict(1'b0);
               return;
            end
            m = mask_store[mask_position];
            if (m == CH_STAR) begin
               mask_position++;
               if (mask_position >= mask_length) begin
                  settle_verdict(1'b1);
                  return;
               end
               star_skipping = 1'b1;
               continue;
            end
            if (m != CH_QMARK && upcase(m) != upcase(c)) begin
               settle_verdict(1'b0);
               return;
            end
            mask_position++;
            return;
         end
      endfunction

      function void note_request(kind_type kind, bit [7:0] c, bit last);
         bit result;
         case (kind)
            KIND_MASK: begin
               if (load_pointer < MASK_DEPTH_DEFAULT) begin
                  mask_store[load_pointer] = c;
                  load_pointer++;
               end
               if (last) begin
                  mask_length   = load_pointer;
                  load_pointer  = '0;
                  star_dot_star = mask_length == SDS_LEN && mask_store[0] == CH_STAR &&
                                  mask_store[1] == CH_DOT && mask_store[2] == CH_STAR;
                  restart_name();
               end
            end
            KIND_CLEAR: begin
               mask_length   = '0;
               load_pointer  = '0;
               star_dot_star = 1'b0;
               restart_name();
            end
            KIND_NAME: begin
               if (c == CH_DOT) begin
                  if (dot_count != DOTS_MAX) begin
                     dot_count++;
                  end
               end else begin
                  all_dots = 1'b0;
               end
               step_name(c);
               if (last) begin
                  // The names "." and ".." never match, whatever the mask.
                  if (all_dots && (dot_count == 2'd1 || dot_count == 2'd2)) begin
                     result = 1'b0;
                  end else if (star_dot_star) begin
                     result = 1'b1;
                  end else if (verdict_fixed) begin
                     result = verdict_value;
                  end else begin
                     result = !star_skipping && mask_position == mask_length;
                  end
                  pending_matches.push_back(result);
                  restart_name();
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void note_failure(string what);
         failures++;
         if (failures <= 10) begin
            $display("ERROR at %0t: %s", $time, what);
         end
      endfunction

      function void check_match(logic got);
         bit want;
         if (pending_matches.size() == 0) begin
            note_failure($sformatf("match beat %b with no name waiting", got));
            return;
         end
         want = pending_matches.pop_front();
         if (got !== want) begin
            note_failure($sformatf("match expected %b, got %b", want, got));
         end
      endfunction
   endclass

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [1:0] req_kind       = KIND_NAME;
   logic [7:0] req_byte_value = 8'h00;
   logic       req_last       = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic       rsp_match;

   name_match_scoreboard sb;
   int req_idle_pct = 22;
   int rsp_idle_pct = 71;
   int beats_sent   = 0;
   int cycle_count  = 0;

   wildcard_name_matcher u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_match      (rsp_match)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Both channels are sampled on the edge, before this edge's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready === 1'b1) begin
            sb.note_request(kind_type'(req_kind), req_byte_value, req_last);
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            sb.check_match(rsp_match);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // One request beat, after a random number of idle cycles.
   task automatic send_beat(input logic [1:0] kind, input logic [7:0] value,
                            input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_byte_value <= value;
      req_last       <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (kind != KIND_RSVD) begin
         beats_sent++;
      end
   endtask

   task automatic send_bytes(input kind_type kind, input bit [7:0] q[$], input bit close);
      foreach (q[i]) begin
         send_beat(kind, q[i], close && i == q.size() - 1);
      end
   endtask

   task automatic send_text(input kind_type kind, input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_beat(kind, s[i], i == s.len() - 1);
      end
   endtask

   // Hold the sender off until every name has had its match beat.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_matches.size() != 0);
   endtask

   function automatic bit [7:0] pick_letter();
      bit [7:0] l;
      l = CH_UPPER_A + 8'($urandom_range(25));
      if ($urandom_range(1)) begin
         l = l | CASE_DELTA;
      end
      return l;
   endfunction

   function automatic bit [7:0] pick_pattern_char();
      int r;
      r = $urandom_range(99);
      if (r < 20) begin
         return CH_STAR;
      end else if (r < 32) begin
         return CH_QMARK;
      end else if (r < 42) begin
         return CH_DOT;
      end else if (r < 48) begin
         return 8'($urandom_range(255));
      end
      return pick_letter();
   endfunction

   function automatic void make_mask(output bit [7:0] q[$], input int n);
      q = {};
      if ($urandom_range(19) == 0) begin
         q = {CH_STAR, CH_DOT, CH_STAR};
         return;
      end
      repeat (n) begin
         q.push_back(pick_pattern_char());
      end
   endfunction

   // Names are built to fit the mask in use for derived_pct percent of calls, the rest are loose.
   function automatic void make_name(output bit [7:0] q[$], input int derived_pct);
      int       r;
      bit [7:0] m;
      q = {};
      r = $urandom_range(99);
      if (r < derived_pct) begin
         for (int i = 0; i < sb.mask_length; i++) begin
            m = sb.mask_store[i];
            if (m == CH_STAR) begin
               repeat ($urandom_range(2)) begin
                  q.push_back(pick_letter());
               end
            end else if (m == CH_QMARK) begin
               q.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255)) : pick_letter());
            end else begin
               if ((m | CASE_DELTA) >= CH_LOWER_A && (m | CASE_DELTA) <= CH_LOWER_Z &&
                   $urandom_range(1)) begin
                  m = m ^ CASE_DELTA;
               end
               q.push_back(m);
            end
         end
         if ($urandom_range(3) == 0 && q.size() > 0) begin
            q[$urandom_range(q.size() - 1)] = pick_pattern_char();
         end
      end else if (r < derived_pct + 25) begin
         repeat ($urandom_range(1, 8)) begin
            q.push_back(pick_pattern_char());
         end
      end else if (r < derived_pct + 35) begin
         repeat ($urandom_range(1, 3)) begin
            q.push_back(CH_DOT);
         end
      end else begin
         repeat ($urandom_range(1, 6)) begin
            q.push_back(8'($urandom_range(255)));
         end
      end
      if (q.size() == 0) begin
         q.push_back(pick_letter());
      end
   endfunction

   task automatic run_random(input int sender_pct, input int receiver_pct, input int goal);
      bit [7:0] q[$];
      bit [7:0] nq[$];
      int       stop_at;
      int       r;
      int       cut;
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      stop_at      = beats_sent + goal;
      while (beats_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 5) begin
            send_beat(KIND_RSVD, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (r < 9) begin
            send_beat(KIND_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (r < 22) begin
            make_mask(q, $urandom_range(1, 8));
            if (r < 14 && q.size() > 1) begin
               // A name runs while the new mask is partly loaded; the old mask length still holds.
               cut = $urandom_range(1, q.size() - 1);
               for (int i = 0; i < cut; i++) begin
                  send_beat(KIND_MASK, q[i], 1'b0);
               end
               make_name(nq, 55);
               send_bytes(KIND_NAME, nq, 1'b1);
               for (int i = cut; i < q.size(); i++) begin
                  send_beat(KIND_MASK, q[i], i == q.size() - 1);
               end
            end else begin
               send_bytes(KIND_MASK, q, 1'b1);
            end
         end else if (r < 26) begin
            // An unfinished name, continued or cut off by whatever comes next.
            make_name(q, 55);
            send_bytes(KIND_NAME, q, 1'b0);
         end else begin
            make_name(q, 55);
            send_bytes(KIND_NAME, q, 1'b1);
         end
      end
   endtask

   initial begin
      bit [7:0] q[$];
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: the star-dot-star mask and the dot names.
      send_text(KIND_MASK, "*.*");
      send_text(KIND_NAME, ".");
      send_text(KIND_NAME, "..");
      send_text(KIND_NAME, "...");
      // Case folding, a question mark, and a name that ends with only a star left.
      send_text(KIND_MASK, "a?C*");
      send_text(KIND_NAME, "abCd");
      send_text(KIND_NAME, "aXc");
      // A star that skips up to the next mask byte.
      send_text(KIND_MASK, "*x");
      send_text(KIND_NAME, "aaX");
      // A trailing star takes zero and all-ones bytes.
      send_text(KIND_MASK, "*");
      send_beat(KIND_NAME, 8'h00, 1'b0);
      send_beat(KIND_NAME, 8'hff, 1'b1);
      // An empty mask matches nothing; the reserved kind is ignored.
      send_beat(KIND_CLEAR, 8'h00, 1'b1);
      send_text(KIND_NAME, "a");
      send_beat(KIND_RSVD, 8'hff, 1'b1);
      drain();

      run_random(22, 71, 70);
      drain();

      // A mask longer than the store; the overflow bytes are dropped.
      q = {};
      repeat (MASK_DEPTH_DEFAULT + $urandom_range(1, 6)) begin
         q.push_back($urandom_range(99) < 60 ? CH_STAR : pick_letter());
      end
      send_bytes(KIND_MASK, q, 1'b1);
      make_name(q, 100);
      send_bytes(KIND_NAME, q, 1'b1);
      make_name(q, 0);
      send_bytes(KIND_NAME, q, 1'b1);
      drain();

      run_random(71, 22, 70);
      drain();
      run_random(0, 0, 70);
      drain();
      repeat (DRAIN_TAIL) @(posedge clock);

      while (sb.pending_matches.size() != 0) begin
         void'(sb.pending_matches.pop_front());
         sb.note_failure("name finished but no match beat came");
      end
      if (sb.failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/wnm_pkg.sv
hdl/wnm_ram.sv
hdl/wnm_mask_store.sv
hdl/wnm_name_track.sv
hdl/wildcard_name_matcher.sv
bench/tb_wildcard_name_matcher.sv
